### rtl/dcm_crg_pkg.sv
// Shared types, codes and saturating arithmetic helpers for the DCM/CoM reference generator.
// Used by dcm_crg_mul and dcm_com_reference_generator_unit; depends on nothing else.
package dcm_crg_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] REG_DECAY_NORMAL   = 3'd0;
    localparam logic [2:0] REG_DECAY_FIRST    = 3'd1;
    localparam logic [2:0] REG_GROWTH         = 3'd2;
    localparam logic [2:0] REG_OMEGA_GAIN     = 3'd3;
    localparam logic [2:0] REG_OMEGA_DT       = 3'd4;
    localparam logic [2:0] REG_SAMPLES_NORMAL = 3'd5;
    localparam logic [2:0] REG_SAMPLES_FIRST  = 3'd6;

    localparam logic [5:0] SH_FACTOR = 6'd30;
    localparam logic [5:0] SH_OMEGA  = 6'd24;
    localparam logic [5:0] SH_DT     = 6'd32;

    typedef enum logic [2:0] {
        STATUS_ACCEPTED = 3'd0,
        STATUS_SAMPLE   = 3'd1,
        STATUS_LAST     = 3'd2,
        STATUS_FINISHED = 3'd3,
        STATUS_REJECTED = 3'd4
    } status_t;

    typedef struct packed {
        logic              start;
        logic signed [33:0] a;
        logic [31:0]       b;
        logic [5:0]        sh;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic        neg;
        logic [64:0] mag;
    } mul_rsp_t;

    function automatic logic signed [33:0] sub_ext(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        return {{2{x[31]}}, x} - {{2{y[31]}}, y};
    endfunction

    function automatic logic signed [31:0] mul_fin(input logic neg, input logic [64:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            if (mag > 65'h0_8000_0000) begin
                r = 32'sh8000_0000;
            end
            else begin
                r = -$signed(mag[31:0]);
            end
        end
        else begin
            if (mag > 65'h0_7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end
            else begin
                r = $signed(mag[31:0]);
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {x[31], x} + {y[31], y};
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/dcm_crg_mul.sv
// Bit-serial sign-magnitude multiplier: one multiplier bit per cycle.
// Depends on dcm_crg_pkg for the request and response structs.
module dcm_crg_mul
    import dcm_crg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic [32:0] m_reg;
    logic [31:0] b_reg;
    logic [32:0] hi_reg;
    logic [31:0] lo_reg;
    logic [5:0]  sh_reg;
    logic [33:0] sum;
    logic [33:0] abs_a;
    logic [64:0] prod;
    logic [64:0] mag;

    assign abs_a = req.a[33] ? 34'(-req.a) : 34'(req.a);
    assign sum   = {1'b0, hi_reg} + (b_reg[0] ? {1'b0, m_reg} : 34'd0);
    assign prod  = {hi_reg, lo_reg};

    always_comb
    begin
        case (sh_reg)
            SH_FACTOR: mag = prod >> 30;
            SH_OMEGA:  mag = prod >> 24;
            SH_DT:     mag = prod >> 32;
            default:   mag = prod;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.a[33];
            m_reg   <= abs_a[32:0];
            b_reg   <= req.b;
            sh_reg  <= req.sh;
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[33:1];
            lo_reg <= {sum[0], lo_reg[31:1]};
            b_reg  <= {1'b0, b_reg[31:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.neg  = neg_reg;
    assign rsp.mag  = mag;

endmodule

### rtl/dcm_com_reference_generator_unit.sv
// Top level of the DCM/CoM reference generator: control sequencer, footstep stores, I/O registers.
// Depends on dcm_crg_pkg and two dcm_crg_mul instances (x and y lanes).
//
// Usage: configuration registers are written through cfg_we/cfg_index/cfg_data while idle.
// Input items (operation, pos_x, pos_y) are taken when req_valid is high and req_stall low;
// each item yields exactly one result item on the rsp channel, taken when rsp_valid is high
// and rsp_stall low. The block works on one item at a time and holds req_stall high until
// that item's result sits in the output register.
// A load, a rejected item or a tick after the end goes from ST_IDLE straight to ST_DONE;
// from ST_DONE its result is registered into the output register once that is free.
// A tick passes ST_T_RD and then runs five rounds on the bit-serial multipliers (DCM,
// DCM velocity, CoM velocity, CoM, growth), each through ST_ISSUE, ST_WAIT and ST_WB.
// A start walks the footstep store backward, one multiply round per step above step 0,
// each round through ST_S_RD, ST_S_LAT, ST_S_CHK, ST_ISSUE, ST_WAIT and ST_WB.
// Reset clears all control state and loads the configuration defaults; the footstep
// stores hold garbage until loaded. While the receiver stalls, the result is held
// and no new item is taken once the sequencer finishes the next one.
module dcm_com_reference_generator_unit
    import dcm_crg_pkg::*;
#(
    parameter int MAX_STEPS            = 64,
    parameter int MAX_SAMPLES_PER_STEP = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         operation,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic signed [31:0] dcm_x,
    output logic signed [31:0] dcm_y,
    output logic signed [31:0] dcm_vel_x,
    output logic signed [31:0] dcm_vel_y,
    output logic signed [31:0] com_x,
    output logic signed [31:0] com_y,
    output logic signed [31:0] com_vel_x,
    output logic signed [31:0] com_vel_y
);

    localparam int AW    = $clog2(MAX_STEPS);
    localparam int SC_W  = $clog2(MAX_STEPS + 1);
    localparam int CNT_W = $clog2(MAX_SAMPLES_PER_STEP + 1);
    localparam int NW    = (CNT_W > 13) ? CNT_W : 13;

    typedef enum logic [3:0] {
        ST_IDLE, ST_S_RD, ST_S_LAT, ST_S_CHK, ST_T_RD, ST_ISSUE, ST_WAIT, ST_WB, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_LOADING, PH_RUNNING, PH_FINISHED
    } phase_t;

    typedef enum logic [2:0] {
        RND_END, RND_DCM, RND_VEL, RND_CVEL, RND_COM, RND_GROW
    } round_t;

    logic [31:0] decay_normal_reg, decay_first_reg, growth_reg, omega_gain_reg, omega_dt_reg;
    logic [12:0] samples_normal_reg, samples_first_reg;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    round_t round_reg, round_next;
    logic [SC_W-1:0] step_count_reg, step_count_next;
    logic [SC_W-1:0] cur_step_reg, cur_step_next;
    logic [NW-1:0]   sidx_reg, sidx_next;
    logic [31:0]     rf_reg, rf_next;
    logic signed [31:0] comx_reg, comx_next, comy_reg, comy_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            first_reg, first_next;
    logic signed [31:0] fzx_reg, fzx_next, fzy_reg, fzy_next;
    logic signed [31:0] cex_reg, cex_next, cey_reg, cey_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next;

    status_t            pst_reg, pst_next;
    logic signed [31:0] pvx_reg, pvx_next, pvy_reg, pvy_next;
    logic signed [31:0] pcx_reg, pcx_next, pcy_reg, pcy_next;
    logic signed [31:0] pcvx_reg, pcvx_next, pcvy_reg, pcvy_next;

    logic               rsp_valid_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] dcm_x_reg, dcm_y_reg, dcm_vel_x_reg, dcm_vel_y_reg;
    logic signed [31:0] com_x_reg, com_y_reg, com_vel_x_reg, com_vel_y_reg;

    logic signed [31:0] foot_x_mem [MAX_STEPS];
    logic signed [31:0] foot_y_mem [MAX_STEPS];
    logic signed [31:0] end_x_mem [MAX_STEPS];
    logic signed [31:0] end_y_mem [MAX_STEPS];
    logic signed [31:0] fx_rd_reg, fy_rd_reg, ex_rd_reg, ey_rd_reg;

    logic               foot_we, end_we;
    logic [AW-1:0]      foot_waddr, end_waddr;
    logic signed [31:0] foot_wx, foot_wy, end_wx, end_wy;

    mul_req_t           mreq_x, mreq_y;
    mul_rsp_t           mrsp_x, mrsp_y;
    logic signed [31:0] rx, ry;
    logic [31:0]        g_sat;

    logic               accept;
    logic               out_free;
    phase_t             ph_eff;
    logic [SC_W-1:0]    cnt_eff;
    logic [12:0]        samp_raw;
    logic [NW-1:0]      n_eff;
    logic [NW:0]        sidx_inc;
    logic [SC_W-1:0]    step_inc;
    logic [SC_W-1:0]    cnt_m1;

    dcm_crg_mul u_mul_x (.clk(clk), .rst_n(rst_n), .req(mreq_x), .rsp(mrsp_x));
    dcm_crg_mul u_mul_y (.clk(clk), .rst_n(rst_n), .req(mreq_y), .rsp(mrsp_y));

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign rx    = mul_fin(mrsp_x.neg, mrsp_x.mag);
    assign ry    = mul_fin(mrsp_y.neg, mrsp_y.mag);
    assign g_sat = (mrsp_x.mag > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : mrsp_x.mag[31:0];

    assign ph_eff  = (phase_reg == PH_FINISHED) ? PH_LOADING : phase_reg;
    assign cnt_eff = (phase_reg == PH_FINISHED) ? '0 : step_count_reg;
    assign cnt_m1  = step_count_reg - SC_W'(1);

    assign samp_raw = (cur_step_reg == '0) ? samples_first_reg : samples_normal_reg;

    always_comb
    begin
        n_eff = NW'(samp_raw);
        if (n_eff == '0)
        begin
            n_eff = NW'(1);
        end
        else if (n_eff > NW'(MAX_SAMPLES_PER_STEP))
        begin
            n_eff = NW'(MAX_SAMPLES_PER_STEP);
        end
    end

    assign sidx_inc = {1'b0, sidx_reg} + (NW+1)'(1);
    assign step_inc = cur_step_reg + SC_W'(1);

    always_comb
    begin
        mreq_x.start = (state_reg == ST_ISSUE);
        mreq_y.start = (state_reg == ST_ISSUE);
        case (round_reg)
            RND_END:
            begin
                mreq_x.a = sub_ext(cex_reg, fzx_reg);
                mreq_y.a = sub_ext(cey_reg, fzy_reg);
                mreq_x.b = decay_normal_reg;
                mreq_x.sh = SH_FACTOR;
            end
            RND_DCM:
            begin
                mreq_x.a = sub_ext(ex_rd_reg, fx_rd_reg);
                mreq_y.a = sub_ext(ey_rd_reg, fy_rd_reg);
                mreq_x.b = rf_reg;
                mreq_x.sh = SH_FACTOR;
            end
            RND_VEL:
            begin
                mreq_x.a = sub_ext(dx_reg, fx_rd_reg);
                mreq_y.a = sub_ext(dy_reg, fy_rd_reg);
                mreq_x.b = omega_gain_reg;
                mreq_x.sh = SH_OMEGA;
            end
            RND_CVEL:
            begin
                mreq_x.a = sub_ext(dx_reg, comx_reg);
                mreq_y.a = sub_ext(dy_reg, comy_reg);
                mreq_x.b = omega_gain_reg;
                mreq_x.sh = SH_OMEGA;
            end
            RND_COM:
            begin
                mreq_x.a = sub_ext(dx_reg, comx_reg);
                mreq_y.a = sub_ext(dy_reg, comy_reg);
                mreq_x.b = omega_dt_reg;
                mreq_x.sh = SH_DT;
            end
            default:
            begin
                mreq_x.a = {2'b00, rf_reg};
                mreq_y.a = '0;
                mreq_x.b = growth_reg;
                mreq_x.sh = SH_FACTOR;
            end
        endcase
        mreq_y.b  = mreq_x.b;
        mreq_y.sh = mreq_x.sh;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        round_next      = round_reg;
        step_count_next = step_count_reg;
        cur_step_next   = cur_step_reg;
        sidx_next       = sidx_reg;
        rf_next         = rf_reg;
        comx_next       = comx_reg;
        comy_next       = comy_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        fzx_next        = fzx_reg;
        fzy_next        = fzy_reg;
        cex_next        = cex_reg;
        cey_next        = cey_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        pst_next        = pst_reg;
        pvx_next        = pvx_reg;
        pvy_next        = pvy_reg;
        pcx_next        = pcx_reg;
        pcy_next        = pcy_reg;
        pcvx_next       = pcvx_reg;
        pcvy_next       = pcvy_reg;
        foot_we         = 1'b0;
        foot_waddr      = cnt_eff[AW-1:0];
        foot_wx         = pos_x;
        foot_wy         = pos_y;
        end_we          = 1'b0;
        end_waddr       = idx_reg;
        end_wx          = fx_rd_reg;
        end_wy          = fy_rd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pst_next  = STATUS_REJECTED;
                    dx_next   = '0;
                    dy_next   = '0;
                    pvx_next  = '0;
                    pvy_next  = '0;
                    pcx_next  = '0;
                    pcy_next  = '0;
                    pcvx_next = '0;
                    pcvy_next = '0;
                    state_next = ST_DONE;
                    case (operation)
                        OP_LOAD:
                        begin
                            phase_next      = ph_eff;
                            step_count_next = cnt_eff;
                            if (ph_eff == PH_LOADING && cnt_eff < SC_W'(MAX_STEPS))
                            begin
                                foot_we         = 1'b1;
                                step_count_next = cnt_eff + SC_W'(1);
                                pst_next        = STATUS_ACCEPTED;
                            end
                        end
                        OP_START:
                        begin
                            if (phase_reg != PH_RUNNING && step_count_reg != '0)
                            begin
                                comx_next  = pos_x;
                                comy_next  = pos_y;
                                idx_next   = cnt_m1[AW-1:0];
                                first_next = 1'b1;
                                round_next = RND_END;
                                state_next = ST_S_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (phase_reg == PH_FINISHED)
                            begin
                                pst_next = STATUS_FINISHED;
                            end
                            else if (phase_reg == PH_RUNNING && cur_step_reg < step_count_reg)
                            begin
                                idx_next   = cur_step_reg[AW-1:0];
                                round_next = RND_DCM;
                                state_next = ST_T_RD;
                            end
                        end
                        default:
                        begin
                            pst_next = STATUS_REJECTED;
                        end
                    endcase
                end
            end
            ST_S_RD:
            begin
                state_next = ST_S_LAT;
            end
            ST_S_LAT:
            begin
                fzx_next = fx_rd_reg;
                fzy_next = fy_rd_reg;
                if (first_reg)
                begin
                    cex_next   = fx_rd_reg;
                    cey_next   = fy_rd_reg;
                    end_we     = 1'b1;
                    first_next = 1'b0;
                end
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                if (idx_reg == '0)
                begin
                    cur_step_next = '0;
                    sidx_next     = '0;
                    rf_next       = decay_first_reg;
                    phase_next    = PH_RUNNING;
                    pst_next      = STATUS_ACCEPTED;
                    state_next    = ST_DONE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_T_RD:
            begin
                pcx_next   = comx_reg;
                pcy_next   = comy_reg;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mrsp_x.done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                state_next = ST_ISSUE;
                case (round_reg)
                    RND_END:
                    begin
                        cex_next   = add_sat(fzx_reg, rx);
                        cey_next   = add_sat(fzy_reg, ry);
                        end_we     = 1'b1;
                        end_waddr  = idx_reg - AW'(1);
                        end_wx     = add_sat(fzx_reg, rx);
                        end_wy     = add_sat(fzy_reg, ry);
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_S_RD;
                    end
                    RND_DCM:
                    begin
                        dx_next    = add_sat(fx_rd_reg, rx);
                        dy_next    = add_sat(fy_rd_reg, ry);
                        round_next = RND_VEL;
                    end
                    RND_VEL:
                    begin
                        pvx_next   = rx;
                        pvy_next   = ry;
                        round_next = RND_CVEL;
                    end
                    RND_CVEL:
                    begin
                        pcvx_next  = rx;
                        pcvy_next  = ry;
                        round_next = RND_COM;
                    end
                    RND_COM:
                    begin
                        comx_next  = add_sat(comx_reg, rx);
                        comy_next  = add_sat(comy_reg, ry);
                        round_next = RND_GROW;
                    end
                    default:
                    begin
                        pst_next = STATUS_SAMPLE;
                        if (sidx_inc >= {1'b0, n_eff})
                        begin
                            sidx_next     = '0;
                            cur_step_next = step_inc;
                            rf_next       = decay_normal_reg;
                            if (step_inc >= step_count_reg)
                            begin
                                phase_next = PH_FINISHED;
                                pst_next   = STATUS_LAST;
                            end
                        end
                        else
                        begin
                            sidx_next = sidx_inc[NW-1:0];
                            rf_next   = g_sat;
                        end
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_normal_reg   <= '0;
            decay_first_reg    <= '0;
            growth_reg         <= 32'h4000_0000;
            omega_gain_reg     <= '0;
            omega_dt_reg       <= '0;
            samples_normal_reg <= 13'd1;
            samples_first_reg  <= 13'd1;
            state_reg          <= ST_IDLE;
            phase_reg          <= PH_LOADING;
            round_reg          <= RND_END;
            step_count_reg     <= '0;
            cur_step_reg       <= '0;
            sidx_reg           <= '0;
            rf_reg             <= '0;
            comx_reg           <= '0;
            comy_reg           <= '0;
            idx_reg            <= '0;
            first_reg          <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DECAY_NORMAL:   decay_normal_reg   <= cfg_data;
                    REG_DECAY_FIRST:    decay_first_reg    <= cfg_data;
                    REG_GROWTH:         growth_reg         <= cfg_data;
                    REG_OMEGA_GAIN:     omega_gain_reg     <= cfg_data;
                    REG_OMEGA_DT:       omega_dt_reg       <= cfg_data;
                    REG_SAMPLES_NORMAL: samples_normal_reg <= cfg_data[12:0];
                    REG_SAMPLES_FIRST:  samples_first_reg  <= cfg_data[12:0];
                    default:            ;
                endcase
            end
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            round_reg      <= round_next;
            step_count_reg <= step_count_next;
            cur_step_reg   <= cur_step_next;
            sidx_reg       <= sidx_next;
            rf_reg         <= rf_next;
            comx_reg       <= comx_next;
            comy_reg       <= comy_next;
            idx_reg        <= idx_next;
            first_reg      <= first_next;
            if (state_reg == ST_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fzx_reg  <= fzx_next;
        fzy_reg  <= fzy_next;
        cex_reg  <= cex_next;
        cey_reg  <= cey_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        pst_reg  <= pst_next;
        pvx_reg  <= pvx_next;
        pvy_reg  <= pvy_next;
        pcx_reg  <= pcx_next;
        pcy_reg  <= pcy_next;
        pcvx_reg <= pcvx_next;
        pcvy_reg <= pcvy_next;
        if (state_reg == ST_DONE && out_free)
        begin
            status_reg    <= pst_reg;
            dcm_x_reg     <= dx_reg;
            dcm_y_reg     <= dy_reg;
            dcm_vel_x_reg <= pvx_reg;
            dcm_vel_y_reg <= pvy_reg;
            com_x_reg     <= pcx_reg;
            com_y_reg     <= pcy_reg;
            com_vel_x_reg <= pcvx_reg;
            com_vel_y_reg <= pcvy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (foot_we)
        begin
            foot_x_mem[foot_waddr] <= foot_wx;
            foot_y_mem[foot_waddr] <= foot_wy;
        end
        if (end_we)
        begin
            end_x_mem[end_waddr] <= end_wx;
            end_y_mem[end_waddr] <= end_wy;
        end
        fx_rd_reg <= foot_x_mem[idx_reg];
        fy_rd_reg <= foot_y_mem[idx_reg];
        ex_rd_reg <= end_x_mem[idx_reg];
        ey_rd_reg <= end_y_mem[idx_reg];
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign dcm_x     = dcm_x_reg;
    assign dcm_y     = dcm_y_reg;
    assign dcm_vel_x = dcm_vel_x_reg;
    assign dcm_vel_y = dcm_vel_y_reg;
    assign com_x     = com_x_reg;
    assign com_y     = com_y_reg;
    assign com_vel_x = com_vel_x_reg;
    assign com_vel_y = com_vel_y_reg;

endmodule
